[src/assert_macros.svh]
// Assertion macros for the verification checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, switched off while rst_n is low.
`define CCDRR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ccdrr checker: property failed");

// Concurrent check on clk that also runs while rst_n is low.
`define CCDRR_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ccdrr checker: reset property failed");

`endif

[src/ccdrr_pkg.sv]
// Shared types, constants and fixed channel tables of the CCD pixel reorder block.
`default_nettype none

package ccdrr_pkg;

  // Fixed geometry of the readout chip
  localparam int CHANNELS      = 192;
  localparam int COLS_PER_HALF = 96;
  localparam int CH_W          = 8;
  localparam int MAP_W         = 7;
  localparam int ROW_W         = 9;
  localparam int ROWS_CFG_W    = 10;
  localparam int STALE_W       = 4;
  localparam int SKIP_W        = 12;
  localparam int ADDR_W        = 20;
  localparam int VALUE_W       = 16;
  // x index width, sized for the widest frame (16 subcolumns: 1536 columns)
  localparam int XDEX_W        = 11;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 10;

  // Parameter defaults
  localparam int SUBCOLUMNS_DEF = 10;
  localparam int MAX_ROWS_DEF   = 512;

  // Register reset values
  localparam logic [ROWS_CFG_W-1:0] ROWS_RST  = 10'd480;
  localparam logic [STALE_W-1:0]    STALE_RST = 4'd7;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_HALF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_CONV    = 1'b1;

  // Channel group layout used to build the tables
  localparam int GROUP_MOD = 193;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_address;
    logic [VALUE_W-1:0] pixel_value;
    logic               frame_last;
  } out_item_t;

  // One tagged sample between the counter stage and the address stage
  typedef struct packed {
    logic [ADDR_W-1:0]  row_term;
    logic [XDEX_W-1:0]  col_term;
    logic [VALUE_W-1:0] value;
    logic               last;
  } tag_t;

  typedef logic [CHANNELS-1:0][MAP_W-1:0] chmap_t;
  typedef logic [CHANNELS-1:0]            halfsel_t;

  // Channel to column-group map; channels not covered stay at 0
  function automatic chmap_t build_chan_map();
    chmap_t m;
    int     g;
    int     k;
    int     base;
    int     col;
    m = '0;
    for (g = 0; g < 3; g++) begin
      base = (g == 0) ? 129 : ((g == 1) ? 66 : 3);
      for (k = 0; k < 16; k++) begin
        col = (base + 16 * k) % GROUP_MOD;
        if (col + 12 < CHANNELS) begin
          m[col]      = MAP_W'(16 * (2 - g) + k);
          m[col + 4]  = MAP_W'(16 * (5 - g) + k);
          m[col + 8]  = MAP_W'(16 * (2 - g) + k);
          m[col + 12] = MAP_W'(16 * (5 - g) + k);
        end
      end
    end
    return m;
  endfunction

  // Top (0) or bottom (1) half for each channel
  function automatic halfsel_t build_half_sel();
    halfsel_t h;
    int       g;
    int       k;
    int       base;
    int       col;
    h = '0;
    for (g = 0; g < 3; g++) begin
      base = (g == 0) ? 129 : ((g == 1) ? 66 : 3);
      for (k = 0; k < 16; k++) begin
        col = (base + 16 * k) % GROUP_MOD;
        if (col + 12 < CHANNELS) begin
          h[col]      = 1'b0;
          h[col + 4]  = 1'b0;
          h[col + 8]  = 1'b1;
          h[col + 12] = 1'b1;
        end
      end
    end
    return h;
  endfunction

  localparam chmap_t   CHAN_MAP = build_chan_map();
  localparam halfsel_t HALF_SEL = build_half_sel();

endpackage

`default_nettype wire

[src/ccdrr_tagger.sv]
// Byte pairing, stale-sample skip, channel/subcolumn/row counters and first pipe register.
`default_nettype none

module ccdrr_tagger #(
  parameter int SUBCOLUMNS = ccdrr_pkg::SUBCOLUMNS_DEF,
  parameter int MAX_ROWS   = ccdrr_pkg::MAX_ROWS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire ccdrr_pkg::in_item_t                 in_data,
  input  wire logic [ccdrr_pkg::ROWS_CFG_W-1:0]    rows_per_half,
  input  wire logic [ccdrr_pkg::STALE_W-1:0]       stale_conversions,
  output logic                                     tag_valid,
  output ccdrr_pkg::tag_t                          tag,
  input  wire logic                                tag_stall
);
  import ccdrr_pkg::*;

  localparam int SUB_W = (SUBCOLUMNS > 1) ? $clog2(SUBCOLUMNS) : 1;
  localparam logic [XDEX_W-1:0]     WIDTH_C = XDEX_W'(COLS_PER_HALF * SUBCOLUMNS);
  localparam logic [XDEX_W-1:0]     SUBS_C  = XDEX_W'(SUBCOLUMNS);
  localparam logic [SUB_W-1:0]      SUB_LAST = SUB_W'(SUBCOLUMNS - 1);
  localparam logic [CH_W-1:0]       CH_LAST  = CH_W'(CHANNELS - 1);
  localparam logic [ROWS_CFG_W-1:0] ROWS_MAX = ROWS_CFG_W'(MAX_ROWS);

  logic               phase_r, phase_nxt;
  logic [7:0]         held_r, held_nxt;
  logic [SKIP_W-1:0]  skip_r, skip_nxt;
  logic [CH_W-1:0]    ch_r, ch_nxt;
  logic [SUB_W-1:0]   sub_r, sub_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               tag_valid_r, tag_valid_nxt;
  tag_t               tag_r, tag_nxt;

  logic               accept;
  logic               phase_e;
  logic [7:0]         held_e;
  logic [SKIP_W-1:0]  skip_e;
  logic [CH_W-1:0]    ch_e;
  logic [SUB_W-1:0]   sub_e;
  logic [ROW_W-1:0]   row_e;
  logic [SKIP_W-1:0]  skip_lim;
  logic [ROWS_CFG_W-1:0] rows_eff;
  logic [MAP_W-1:0]   map_val;
  logic               half;
  logic [XDEX_W-1:0]  xdex;
  logic               last;

  // First stage holds while its sample waits for the address stage
  assign in_stall  = tag_valid_r && tag_stall;
  assign accept    = in_valid && !in_stall;
  assign tag_valid = tag_valid_r;
  assign tag       = tag_r;

  // Counters as seen by this byte: frame_start clears them first
  assign phase_e = in_data.frame_start ? 1'b0 : phase_r;
  assign held_e  = in_data.frame_start ? '0 : held_r;
  assign skip_e  = in_data.frame_start ? '0 : skip_r;
  assign ch_e    = in_data.frame_start ? '0 : ch_r;
  assign sub_e   = in_data.frame_start ? '0 : sub_r;
  assign row_e   = in_data.frame_start ? '0 : row_r;

  // Stale sample limit and clamped row count
  assign skip_lim = SKIP_W'(stale_conversions) * SKIP_W'(CHANNELS);

  always_comb begin
    rows_eff = rows_per_half;
    if (rows_eff == '0) begin
      rows_eff = ROWS_CFG_W'(1);
    end
    if (rows_eff > ROWS_MAX) begin
      rows_eff = ROWS_MAX;
    end
  end

  // Table lookups and column index within the half
  assign map_val = CHAN_MAP[ch_e];
  assign half    = HALF_SEL[ch_e];
  assign xdex    = XDEX_W'(map_val) * SUBS_C + (SUBS_C - XDEX_W'(1)) - XDEX_W'(sub_e);

  assign last = (ch_e == CH_LAST) && (sub_e == SUB_LAST) &&
                ({1'b0, row_e} >= (rows_eff - ROWS_CFG_W'(1)));

  // Next state for one accepted transaction
  always_comb begin
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    skip_nxt      = skip_r;
    ch_nxt        = ch_r;
    sub_nxt       = sub_r;
    row_nxt       = row_r;
    tag_valid_nxt = tag_stall ? tag_valid_r : 1'b0;
    tag_nxt       = tag_r;
    if (accept) begin
      held_nxt = held_e;
      skip_nxt = skip_e;
      ch_nxt   = ch_e;
      sub_nxt  = sub_e;
      row_nxt  = row_e;
      if (!phase_e) begin
        phase_nxt = 1'b1;
        held_nxt  = in_data.byte_in;
      end else begin
        phase_nxt = 1'b0;
        if (skip_e < skip_lim) begin
          skip_nxt = skip_e + SKIP_W'(1);
        end else begin
          tag_valid_nxt = 1'b1;
          tag_nxt.value = {held_e, in_data.byte_in};
          tag_nxt.last  = last;
          tag_nxt.col_term = half ? (WIDTH_C - xdex - XDEX_W'(1)) : xdex;
          tag_nxt.row_term = half ?
              ((ADDR_W'(rows_eff) << 1) - ADDR_W'(row_e) - ADDR_W'(1)) :
              ADDR_W'(row_e);
          if (last) begin
            held_nxt = '0;
            skip_nxt = '0;
            ch_nxt   = '0;
            sub_nxt  = '0;
            row_nxt  = '0;
          end else if (ch_e != CH_LAST) begin
            ch_nxt = ch_e + CH_W'(1);
          end else begin
            ch_nxt = '0;
            if (sub_e != SUB_LAST) begin
              sub_nxt = sub_e + SUB_W'(1);
            end else begin
              sub_nxt = '0;
              row_nxt = row_e + ROW_W'(1);
            end
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      held_r      <= '0;
      skip_r      <= '0;
      ch_r        <= '0;
      sub_r       <= '0;
      row_r       <= '0;
      tag_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      held_r      <= held_nxt;
      skip_r      <= skip_nxt;
      ch_r        <= ch_nxt;
      sub_r       <= sub_nxt;
      row_r       <= row_nxt;
      tag_valid_r <= tag_valid_nxt;
    end
  end

  // Sample payload
  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

endmodule

`default_nettype wire

[src/ccdrr_addr.sv]
// Frame-store address stage and output register of the CCD pixel reorder block.
`default_nettype none

module ccdrr_addr #(
  parameter int SUBCOLUMNS = ccdrr_pkg::SUBCOLUMNS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 tag_valid,
  input  wire ccdrr_pkg::tag_t      tag,
  output logic                      tag_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ccdrr_pkg::out_item_t      out_data
);
  import ccdrr_pkg::*;

  localparam logic [ADDR_W-1:0] WIDTH_A = ADDR_W'(COLS_PER_HALF * SUBCOLUMNS);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      load;

  // Output register frees when empty or being taken
  assign tag_stall = out_valid_r && out_stall;
  assign load      = !tag_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Row base times frame width plus column, modulo the address width
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = tag_valid;
      out_data_nxt.pixel_address = WIDTH_A * tag.row_term + ADDR_W'(tag.col_term);
      out_data_nxt.pixel_value   = tag.value;
      out_data_nxt.frame_last    = tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

[src/ccd_readout_pixel_reorder_core.sv]
// A low byte that completes a kept sample shows its pixel after the tag register, then the output register.
// Throughput: one byte per cycle while in_stall is low; every second byte can yield one pixel.
// The rate is set by the two-stage path: counter stage, then address multiply stage.
// Reset (rst_n low, synchronous) clears byte phase, counters and valid flags;
// rows_per_half returns to 480 and stale_conversions to 7.
`default_nettype none

module ccd_readout_pixel_reorder_core #(
  parameter int SUBCOLUMNS = ccdrr_pkg::SUBCOLUMNS_DEF,
  parameter int MAX_ROWS   = ccdrr_pkg::MAX_ROWS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire ccdrr_pkg::in_item_t                 in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output ccdrr_pkg::out_item_t                     out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ccdrr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ccdrr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ccdrr_pkg::*;

  logic [ROWS_CFG_W-1:0] rows_r, rows_nxt;
  logic [STALE_W-1:0]    stale_r, stale_nxt;
  logic                  tag_valid;
  tag_t                  tag;
  logic                  tag_stall;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_comb begin
    rows_nxt  = rows_r;
    stale_nxt = stale_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ROWS_PER_HALF: rows_nxt  = cfg_data[ROWS_CFG_W-1:0];
        CFG_STALE_CONV:    stale_nxt = cfg_data[STALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= ROWS_RST;
      stale_r <= STALE_RST;
    end else begin
      rows_r  <= rows_nxt;
      stale_r <= stale_nxt;
    end
  end

  // Sample tagging
  ccdrr_tagger #(
    .SUBCOLUMNS (SUBCOLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_tagger (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data           (in_data),
    .rows_per_half     (rows_r),
    .stale_conversions (stale_r),
    .tag_valid         (tag_valid),
    .tag               (tag),
    .tag_stall         (tag_stall)
  );

  // Address generation and output register
  ccdrr_addr #(
    .SUBCOLUMNS (SUBCOLUMNS)
  ) u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_valid (tag_valid),
    .tag       (tag),
    .tag_stall (tag_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[src/ccdrr_checker.sv]
// Port-level checker for the CCD pixel reorder core, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module ccdrr_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire ccdrr_pkg::in_item_t  in_data,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire ccdrr_pkg::out_item_t out_data
);
  import ccdrr_pkg::*;

  // No result right after reset
  `CCDRR_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid)

  // A fresh result follows an accepted transaction through the tag register and the output register
  `CCDRR_ASSERT(a_out_from_accept, $rose(out_valid) |-> $past(in_valid && !in_stall, 2))

  // A frame_start byte is always a high byte and never completes a pixel
  `CCDRR_ASSERT(a_start_no_pixel, $rose(out_valid) |-> !$past(in_data.frame_start, 2))

  // A stalled result holds
  `CCDRR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))

endmodule

bind ccd_readout_pixel_reorder_core ccdrr_checker u_ccdrr_checker (.*);

`default_nettype wire
